// ===== design/lmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// LED matrix frame buffer scan package
// Beat types, opcodes and default geometry shared by the scan block.
// ----------------------------------------------------------------------------
package lmfs_pkg;

   // Default matrix geometry
   localparam int ROWS_DEFAULT    = 16;
   localparam int COLUMNS_DEFAULT = 64;

   // Opcodes
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_REFRESH = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   // Bits of pixel_color
   localparam int COLOR_RED_BIT   = 1;
   localparam int COLOR_GREEN_BIT = 0;

   // Input beat
   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] pixel_x;
      logic [3:0] pixel_y;
      logic [1:0] pixel_color;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [3:0]  row_address;
      logic [63:0] red_bits;
      logic [63:0] green_bits;
   } rsp_type;

endpackage

// ===== design/led_matrix_framebuffer_scan.sv =====
// ----------------------------------------------------------------------------
// LED matrix frame buffer with row scan
// Two-color frame buffer held in one row memory, read-modify-write pixel
// updates and a multiplexed row refresh output.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one command per beat. Pixel write sets/clears one pixel in
//   both color planes, clear blanks the screen, refresh emits one row.
//   rsp channel: one beat per refresh: the row address plus that row's red
//   and green bits, inverted (active-low drive), pixel x at bit COLUMNS-1-x,
//   bits at COLUMNS and above zero. The scan row then advances, wrapping.
//   Other commands give no beat.
// Pipeline and throughput:
//   A refresh is registered in stage 1 and then in the output register
//   that drives rsp. One command per cycle is accepted while req_stall
//   is low. Each command does one registered read of the row memory, and an
//   in-range pixel write writes the row back; a write in flight is forwarded
//   to a read of the same row issued behind it. Clear drops the per-row
//   valid flags, and a row whose flag is low reads as blank.
// Reset:
//   Synchronous reset blanks the screen and sets the scan row to 0.
// Back-pressure:
//   While rsp_stall holds a result and a refresh waits behind it, req_stall
//   is raised; writes and clears never raise it.
module led_matrix_framebuffer_scan #(
   parameter int ROWS    = lmfs_pkg::ROWS_DEFAULT,
   parameter int COLUMNS = lmfs_pkg::COLUMNS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lmfs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lmfs_pkg::rsp_type rsp_data
);
   import lmfs_pkg::*;

   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int WORD_W = 2 * COLUMNS;

   // Row memory: {red, green}
   logic [WORD_W-1:0] mem [ROWS];
   logic [WORD_W-1:0] rd_data_ff;

   logic [ROWS-1:0]  row_valid_ff, row_valid_in;
   logic [ROW_W-1:0] scan_row_ff, scan_row_in;

   // Stage 1 registers
   logic             s1_valid_ff, s1_valid_in;
   logic [1:0]       s1_op_ff;
   logic [ROW_W-1:0] s1_addr_ff;
   logic             s1_in_range_ff;
   logic [COL_W-1:0] s1_bit_ff;
   logic [1:0]       s1_color_ff;

   // Forwarding of a write back to the row read behind it
   logic              fwd_ff;
   logic [WORD_W-1:0] fwd_data_ff;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic              accept;
   logic              s1_fire;
   logic              s1_is_write;
   logic [ROW_W-1:0]  rd_addr;
   logic              in_range;
   logic [WORD_W-1:0] old_word, new_word;
   logic [COLUMNS-1:0] red_word, green_word;

   // Handshake
   always_comb begin
      s1_fire   = s1_valid_ff && ((s1_op_ff != OP_REFRESH) || !rsp_valid_ff || !rsp_stall);
      req_stall = s1_valid_ff && !s1_fire;
      accept    = req_valid && !req_stall;
   end

   // Stage 0: pick the row to read
   always_comb begin
      in_range = (32'(req_data.pixel_y) < ROWS) && (32'(req_data.pixel_x) < COLUMNS);
      if (req_data.opcode == OP_REFRESH) begin
         rd_addr = scan_row_ff;
      end else begin
         rd_addr = req_data.pixel_y[ROW_W-1:0];
      end
      if (scan_row_ff == ROW_W'(ROWS - 1)) begin
         scan_row_in = '0;
      end else begin
         scan_row_in = scan_row_ff + 1'b1;
      end
   end

   // Stage 1: modify the row word
   always_comb begin
      s1_is_write = s1_valid_ff && (s1_op_ff == OP_WRITE) && s1_in_range_ff;
      if (!row_valid_ff[s1_addr_ff]) begin
         old_word = '0;
      end else if (fwd_ff) begin
         old_word = fwd_data_ff;
      end else begin
         old_word = rd_data_ff;
      end
      red_word   = old_word[WORD_W-1:COLUMNS];
      green_word = old_word[COLUMNS-1:0];
      red_word[s1_bit_ff]   = s1_color_ff[COLOR_RED_BIT];
      green_word[s1_bit_ff] = s1_color_ff[COLOR_GREEN_BIT];
      new_word = {red_word, green_word};
   end

   // Row valid flags
   always_comb begin
      row_valid_in = row_valid_ff;
      if (s1_fire && (s1_op_ff == OP_CLEAR)) begin
         row_valid_in = '0;
      end else if (s1_is_write) begin
         row_valid_in[s1_addr_ff] = 1'b1;
      end
   end

   // Stage 1 and output valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && (s1_op_ff == OP_REFRESH)) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Memory: read at accept, write back from stage 1
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (s1_is_write) begin
         mem[s1_addr_ff] <= new_word;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         scan_row_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept && (req_data.opcode == OP_REFRESH)) begin
            scan_row_ff <= scan_row_in;
         end
      end
   end

   // Stage 1 payload and forwarding
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff       <= req_data.opcode;
         s1_addr_ff     <= rd_addr;
         s1_in_range_ff <= in_range;
         s1_bit_ff      <= COL_W'(COLUMNS - 1) - req_data.pixel_x[COL_W-1:0];
         s1_color_ff    <= req_data.pixel_color;
         fwd_ff         <= s1_is_write && (s1_addr_ff == rd_addr);
         fwd_data_ff    <= new_word;
      end
   end

   // Output payload: inverted row, upper bits zero
   always_ff @(posedge clock) begin
      if (s1_fire && (s1_op_ff == OP_REFRESH)) begin
         rsp_ff.row_address <= 4'(s1_addr_ff);
         rsp_ff.red_bits    <= 64'(COLUMNS'(~old_word[WORD_W-1:COLUMNS]));
         rsp_ff.green_bits  <= 64'(COLUMNS'(~old_word[COLUMNS-1:0]));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // Only a refresh waiting on a full output register holds the input
   a_stall_only_refresh: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && (s1_op_ff == OP_REFRESH) && rsp_valid_ff))
      else $error("input stalled without a blocked refresh");

   // Scan row stays inside the matrix
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(scan_row_ff) < ROWS)
      else $error("scan row out of range");

   // A clear leaves every row blank
   a_clear_blanks: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_op_ff == OP_CLEAR)) |=> (row_valid_ff == '0))
      else $error("clear left a row valid");

   // A pixel write marks its row as holding data
   a_write_marks_row: assert property (@(posedge clock) disable iff (reset)
      s1_is_write |=> row_valid_ff[$past(s1_addr_ff)])
      else $error("written row not marked valid");

   // A refresh leaving stage 1 always lands in the output register
   a_refresh_lands: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_op_ff == OP_REFRESH)) |=> rsp_valid_ff)
      else $error("refresh result lost");
`endif

endmodule
